### sv/scb_pkg.sv
// Package for the color bar pixel generator: geometry widths, reciprocal
// constants, register indexes and the bar color tables.
// No dependencies.
`default_nettype none

package scb_pkg;

    localparam int CFG_DIM_W = 13;   // frame_width / frame_height register width
    localparam int PIX_W     = 12;   // pixel_x / pixel_y width
    localparam int GEO_W     = 15;   // holds 7*barw and 2*H+24 for any 13-bit size
    localparam int PROD_W    = GEO_W + 16;

    // floor(v/d) = (v * RECIP) >> SHIFT, exact over the whole GEO_W input range used
    localparam logic [15:0] RECIP7  = 16'd9363;    // shift 16
    localparam logic [15:0] RECIP3  = 16'd21846;   // shift 16
    localparam logic [15:0] RECIP25 = 16'd41944;   // shift 20
    localparam int          SHIFT16 = 16;
    localparam int          SHIFT20 = 20;

    // geometry pipeline depth after a size change
    localparam logic [2:0] SETTLE_CYCLES = 3'd5;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_SOLID_MODE   = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } rgb_t;

    localparam rgb_t RGB_BLACK = '{r: 8'd0,   g: 8'd0,   b: 8'd0};
    localparam rgb_t RGB_RED   = '{r: 8'd255, g: 8'd0,   b: 8'd0};
    localparam rgb_t RGB_GREY  = '{r: 8'd192, g: 8'd192, b: 8'd192};
    localparam rgb_t RGB_DARK  = '{r: 8'd19,  g: 8'd19,  b: 8'd19};

    function automatic rgb_t top_color(input logic [2:0] idx);
        rgb_t c;
        case (idx)
            3'd0:    c = RGB_GREY;
            3'd1:    c = '{r: 8'd192, g: 8'd192, b: 8'd0};
            3'd2:    c = '{r: 8'd0,   g: 8'd192, b: 8'd192};
            3'd3:    c = '{r: 8'd0,   g: 8'd192, b: 8'd0};
            3'd4:    c = '{r: 8'd192, g: 8'd0,   b: 8'd192};
            3'd5:    c = '{r: 8'd192, g: 8'd0,   b: 8'd0};
            3'd6:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd192};
            default: c = RGB_BLACK;
        endcase
        return c;
    endfunction

    function automatic rgb_t mid_color(input logic [2:0] idx);
        rgb_t c;
        case (idx)
            3'd0:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd192};
            3'd1:    c = RGB_DARK;
            3'd2:    c = '{r: 8'd192, g: 8'd0,   b: 8'd192};
            3'd3:    c = RGB_DARK;
            3'd4:    c = '{r: 8'd0,   g: 8'd192, b: 8'd192};
            3'd5:    c = RGB_DARK;
            3'd6:    c = RGB_GREY;
            default: c = RGB_BLACK;
        endcase
        return c;
    endfunction

    function automatic rgb_t low_color(input logic [1:0] idx);
        rgb_t c;
        case (idx)
            2'd0:    c = '{r: 8'd0,   g: 8'd33,  b: 8'd76};
            2'd1:    c = '{r: 8'd255, g: 8'd255, b: 8'd255};
            2'd2:    c = '{r: 8'd50,  g: 8'd0,   b: 8'd106};
            default: c = RGB_DARK;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### sv/smpte_color_bar_pixel.sv
// Color bar test pattern pixel generator, top level.
// Depends on scb_pkg.
// An accepted input word passes the input register, then the result register
// on its way to the output. Throughput: one word per cycle while m_axis_tready is high.
// Bar edges and band heights come from a 5-stage geometry pipeline off the
// size registers; s_axis_tready is held low after reset and after every
// configuration write while it settles.
// Reset (async, active low): 1920x1080, bars mode, pipeline empty.
`default_nettype none

module smpte_color_bar_pixel #(
    parameter int MAX_DIMENSION = 4096
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration
    input  wire logic                         cfg_wr_en,
    input  wire logic [1:0]                   cfg_index,
    input  wire logic [scb_pkg::CFG_DIM_W-1:0] cfg_wdata,
    // pixel requests
    input  wire logic                         s_axis_tvalid,
    output      logic                         s_axis_tready,
    input  wire logic [23:0]                  s_axis_tdata,   // pixel_x[11:0], pixel_y[23:12]
    // pixel colors
    output      logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output      logic [31:0]                  m_axis_tdata    // red, green, blue, in_frame, 0s
);
    import scb_pkg::*;

    localparam logic [CFG_DIM_W:0] MAX_DIM_L = (CFG_DIM_W + 1)'(MAX_DIMENSION);

    // configuration registers
    logic [CFG_DIM_W-1:0] frame_width_reg;
    logic [CFG_DIM_W-1:0] frame_height_reg;
    logic                 solid_mode_reg;
    logic [2:0]           settle_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CFG_DIM_W'(1920);
            frame_height_reg <= CFG_DIM_W'(1080);
            solid_mode_reg   <= 1'b0;
            settle_reg       <= SETTLE_CYCLES;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                settle_reg <= SETTLE_CYCLES;
                case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                    REG_SOLID_MODE:   solid_mode_reg   <= cfg_wdata[0];
                    default:          ;
                endcase
            end
            else if (settle_reg != 3'd0)
            begin
                settle_reg <= settle_reg - 3'd1;
            end
        end
    end

    // saturated frame size
    logic [CFG_DIM_W:0] w_wide, h_wide;
    logic [GEO_W-1:0]   w_sat, h_sat;

    always_comb
    begin
        w_wide = (({1'b0, frame_width_reg} > MAX_DIM_L)) ? MAX_DIM_L : {1'b0, frame_width_reg};
        h_wide = (({1'b0, frame_height_reg} > MAX_DIM_L)) ? MAX_DIM_L : {1'b0, frame_height_reg};
        w_sat  = GEO_W'(w_wide);
        h_sat  = GEO_W'(h_wide);
    end

    // geometry pipeline
    logic [PROD_W-1:0] prod7_reg, prod3_reg, prod25_reg, prod_sw_reg;
    logic [GEO_W-1:0]  barw_reg, h1_reg, h2_reg, y3_reg, lw_reg, sw_reg;
    logic [GEO_W-1:0]  bar_edge_reg [1:7];   // k * barw
    logic [GEO_W-1:0]  low_edge_reg [1:4];   // k * lw
    logic [GEO_W-1:0]  strip_edge_reg [1:3]; // 5*barw + k*sw
    logic [GEO_W-1:0]  barw5;

    assign barw5 = (barw_reg << 2) + barw_reg;

    always_ff @(posedge clk)
    begin
        // stage 1: reciprocal products
        prod7_reg  <= PROD_W'(w_sat + GEO_W'(6)) * PROD_W'(RECIP7);
        prod3_reg  <= PROD_W'((h_sat << 1) + GEO_W'(2)) * PROD_W'(RECIP3);
        prod25_reg <= PROD_W'((h_sat << 1) + GEO_W'(24)) * PROD_W'(RECIP25);
        // stage 2: bar width and band heights
        barw_reg   <= GEO_W'(prod7_reg[PROD_W-1:SHIFT16]);
        h1_reg     <= GEO_W'(prod3_reg[PROD_W-1:SHIFT16]);
        h2_reg     <= GEO_W'(prod25_reg[PROD_W-1:SHIFT20]);
        // stage 3: bar edges, bottom bar width, strip width product
        y3_reg          <= h1_reg + h2_reg;
        bar_edge_reg[1] <= barw_reg;
        bar_edge_reg[2] <= barw_reg << 1;
        bar_edge_reg[3] <= (barw_reg << 1) + barw_reg;
        bar_edge_reg[4] <= barw_reg << 2;
        bar_edge_reg[5] <= barw5;
        bar_edge_reg[6] <= (barw_reg << 2) + (barw_reg << 1);
        bar_edge_reg[7] <= (barw_reg << 3) - barw_reg;
        lw_reg          <= barw5 >> 2;
        prod_sw_reg     <= PROD_W'(barw_reg) * PROD_W'(RECIP3);
        // stage 4: strip width, bottom bar edges
        sw_reg          <= GEO_W'(prod_sw_reg[PROD_W-1:SHIFT16]);
        low_edge_reg[1] <= lw_reg;
        low_edge_reg[2] <= lw_reg << 1;
        low_edge_reg[3] <= (lw_reg << 1) + lw_reg;
        low_edge_reg[4] <= lw_reg << 2;
        // stage 5: near-black strip edges
        strip_edge_reg[1] <= bar_edge_reg[5] + sw_reg;
        strip_edge_reg[2] <= bar_edge_reg[5] + (sw_reg << 1);
        strip_edge_reg[3] <= bar_edge_reg[5] + (sw_reg << 1) + sw_reg;
    end

    // pixel pipeline handshake
    logic              p_valid_reg, out_valid_reg;
    logic [PIX_W-1:0]  px_reg, py_reg;
    rgb_t              rgb_reg, rgb_next;
    logic              in_frame_reg, in_frame_next;
    logic              advance;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (settle_reg == 3'd0) && !cfg_wr_en && (!p_valid_reg || advance);

    // color lookup
    logic [GEO_W-1:0] xe, ye;
    logic [2:0]       bar_idx;
    logic             bar_out;
    logic [1:0]       low_idx;
    logic [1:0]       strip_idx;
    logic [7:0]       strip_lvl;

    always_comb
    begin
        xe = GEO_W'(px_reg);
        ye = GEO_W'(py_reg);

        bar_out = 1'b0;
        if (xe < bar_edge_reg[1])      bar_idx = 3'd0;
        else if (xe < bar_edge_reg[2]) bar_idx = 3'd1;
        else if (xe < bar_edge_reg[3]) bar_idx = 3'd2;
        else if (xe < bar_edge_reg[4]) bar_idx = 3'd3;
        else if (xe < bar_edge_reg[5]) bar_idx = 3'd4;
        else if (xe < bar_edge_reg[6]) bar_idx = 3'd5;
        else if (xe < bar_edge_reg[7]) bar_idx = 3'd6;
        else
        begin
            bar_idx = 3'd7;
            bar_out = 1'b1;
        end

        if (xe < low_edge_reg[1])      low_idx = 2'd0;
        else if (xe < low_edge_reg[2]) low_idx = 2'd1;
        else if (xe < low_edge_reg[3]) low_idx = 2'd2;
        else                           low_idx = 2'd3;

        if (xe < strip_edge_reg[1])      strip_idx = 2'd0;
        else if (xe < strip_edge_reg[2]) strip_idx = 2'd1;
        else                             strip_idx = 2'd2;
        // 9, 19, 29
        strip_lvl = 8'd9 + ({6'd0, strip_idx} << 3) + ({6'd0, strip_idx} << 1);

        in_frame_next = (xe < w_sat) && (ye < h_sat);
        if (!in_frame_next)
            rgb_next = RGB_BLACK;
        else if (solid_mode_reg)
            rgb_next = RGB_RED;
        else if (ye < h1_reg)
            rgb_next = bar_out ? RGB_BLACK : top_color(bar_idx);
        else if (ye < y3_reg)
            rgb_next = bar_out ? RGB_BLACK : mid_color(bar_idx);
        else if (xe < low_edge_reg[4])
            rgb_next = low_color(low_idx);
        else if (xe >= bar_edge_reg[6] && xe < bar_edge_reg[7])
            rgb_next = RGB_DARK;
        // an empty strip run (zero strip width) makes this range empty
        else if (xe >= bar_edge_reg[5] && xe < strip_edge_reg[3])
            rgb_next = '{r: strip_lvl, g: strip_lvl, b: strip_lvl};
        else
            rgb_next = RGB_BLACK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!p_valid_reg || advance)
                p_valid_reg <= s_axis_tvalid && s_axis_tready;
            if (advance)
                out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            px_reg <= s_axis_tdata[PIX_W-1:0];
            py_reg <= s_axis_tdata[2*PIX_W-1:PIX_W];
        end
        if (advance && p_valid_reg)
        begin
            rgb_reg      <= rgb_next;
            in_frame_reg <= in_frame_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, in_frame_reg, rgb_reg.b, rgb_reg.g, rgb_reg.r};

endmodule

`default_nettype wire
